>>> rtl/core_local_timer_compare_unit_macros.svh
// Assertion macros shared by the checker of the core-local timer compare unit.
// Needs nothing else; the including file supplies clock and reset names.
`ifndef CORE_LOCAL_TIMER_COMPARE_UNIT_MACROS_SVH
`define CORE_LOCAL_TIMER_COMPARE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CLT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clt: implication check failed");

// Next-cycle implication, disabled during reset.
`define CLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clt: next-cycle check failed");

// Next-cycle implication that stays active through reset.
`define CLT_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("clt: reset-time check failed");

`endif

>>> rtl/clt_pkg.sv
// Package for the core-local timer compare unit: widths, offsets, opcodes and types.
// Depends on nothing; every other file of the block but the macro header imports it.
package clt_pkg;

  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned OFFSET_W   = 15;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned TIME_W     = 64;
  localparam int unsigned PEND_W     = 4;
  localparam int unsigned HART_IDX_W = 4;
  localparam int unsigned WORD_IDX_W = OFFSET_W - 3;

  localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd2;

  localparam logic [OFFSET_W-1:0] TIME_LO_OFF = 15'h7ff8;
  localparam logic [OFFSET_W-1:0] TIME_HI_OFF = 15'h7ffc;

  typedef struct packed {
    logic                  hit;
    logic                  is_time;
    logic                  hi_half;
    logic [HART_IDX_W-1:0] hart;
  } access_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [OFFSET_W-1:0] reg_offset;
    logic [WORD_W-1:0]   write_word;
  } in_item_t;

endpackage

>>> rtl/clt_in_if.sv
// Input channel of the core-local timer compare unit: valid, ready and one item.
// Depends on clt_pkg for the field widths.
interface clt_in_if import clt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [OFFSET_W-1:0] reg_offset;
  logic [WORD_W-1:0]   write_word;

  modport source (output valid, output opcode, output reg_offset, output write_word,
                  input ready);
  modport sink (input valid, input opcode, input reg_offset, input write_word,
                output ready);
endinterface

>>> rtl/clt_out_if.sv
// Result channel of the core-local timer compare unit: valid, ready and one item.
// Depends on clt_pkg for the field widths.
interface clt_out_if import clt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] read_word;
  logic              bad_offset;
  logic [PEND_W-1:0] timer_pending;

  modport source (output valid, output read_word, output bad_offset, output timer_pending,
                  input ready);
  modport sink (input valid, input read_word, input bad_offset, input timer_pending,
                output ready);
endinterface

>>> rtl/core_local_timer_compare_unit.sv
// Channel   | Dir | Payload                                  | Handshake
// in_item   | in  | opcode, reg_offset, write_word           | valid/ready
// out_item  | out | read_word, bad_offset, timer_pending     | valid/ready
// Top level of the core-local timer compare unit: input register, decoder,
// timer state and result register. Depends on clt_pkg, the channel interfaces,
// clt_decode and clt_regs.
// One item is taken per clock while the result side does not stall; each item passes
// from the input register to the result register. The timer state updates as the item leaves
// the input register, so each result reflects every earlier item in order.
// A stalled result holds and the input register fills behind it; reset is
// synchronous and empties both registers, clears the counter and sets all compares.
module core_local_timer_compare_unit import clt_pkg::*; #(
  parameter int unsigned NUM_HARTS = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  clt_in_if.sink    in_item,
  clt_out_if.source out_item
);

  logic              s1_valid_r;
  in_item_t          s1_item_r;
  logic              s1_fire;
  logic              in_fire;
  access_t           acc;
  logic [WORD_W-1:0] read_nxt;
  logic              bad_nxt;
  logic [PEND_W-1:0] pending_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [WORD_W-1:0] out_read_r;
  logic              out_bad_r;
  logic [PEND_W-1:0] out_pend_r;

  assign s1_fire       = s1_valid_r && (!out_valid_r || out_item.ready);
  assign in_item.ready = !s1_valid_r || s1_fire;
  assign in_fire       = in_item.valid && in_item.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_item.ready) begin
      s1_valid_r <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.opcode     <= in_item.opcode;
      s1_item_r.reg_offset <= in_item.reg_offset;
      s1_item_r.write_word <= in_item.write_word;
    end
  end

  clt_decode #(
    .NUM_HARTS(NUM_HARTS)
  ) u_decode (
    .reg_offset(s1_item_r.reg_offset),
    .acc       (acc)
  );

  clt_regs #(
    .NUM_HARTS(NUM_HARTS)
  ) u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (s1_fire),
    .opcode     (s1_item_r.opcode),
    .acc        (acc),
    .write_word (s1_item_r.write_word),
    .read_nxt   (read_nxt),
    .bad_nxt    (bad_nxt),
    .pending_nxt(pending_nxt)
  );

  always_comb begin
    out_valid_nxt = out_valid_r && !out_item.ready;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_read_r <= read_nxt;
      out_bad_r  <= bad_nxt;
      out_pend_r <= pending_nxt;
    end
  end

  assign out_item.valid         = out_valid_r;
  assign out_item.read_word     = out_read_r;
  assign out_item.bad_offset    = out_bad_r;
  assign out_item.timer_pending = out_pend_r;

endmodule

>>> rtl/clt_decode.sv
// Address decoder: maps a byte offset to the counter or a hart's compare register.
// Depends on clt_pkg.
module clt_decode import clt_pkg::*; #(
  parameter int unsigned NUM_HARTS
) (
  input  logic [OFFSET_W-1:0] reg_offset,
  output access_t             acc
);

  logic [WORD_IDX_W-1:0] word_idx;
  logic                  aligned;
  logic                  time_hit;
  logic                  cmp_hit;

  assign word_idx = reg_offset[OFFSET_W-1:3];
  assign aligned  = (reg_offset[1:0] == 2'b00);
  assign time_hit = (reg_offset == TIME_LO_OFF) || (reg_offset == TIME_HI_OFF);
  assign cmp_hit  = (word_idx < WORD_IDX_W'(NUM_HARTS));

  always_comb begin
    acc.hit     = aligned && (time_hit || cmp_hit);
    acc.is_time = time_hit;
    acc.hi_half = reg_offset[2];
    acc.hart    = word_idx[HART_IDX_W-1:0];
  end

endmodule

>>> rtl/clt_regs.sv
// Timer state: the 64-bit counter and the per-hart compare registers, with read
// data and the pending compare of the next state. Depends on clt_pkg.
module clt_regs import clt_pkg::*; #(
  parameter int unsigned NUM_HARTS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                upd,
  input  logic [OPCODE_W-1:0] opcode,
  input  access_t             acc,
  input  logic [WORD_W-1:0]   write_word,
  output logic [WORD_W-1:0]   read_nxt,
  output logic                bad_nxt,
  output logic [PEND_W-1:0]   pending_nxt
);

  localparam int unsigned HART_W = (NUM_HARTS > 1) ? $clog2(NUM_HARTS) : 1;

  logic [TIME_W-1:0] time_r;
  logic [TIME_W-1:0] time_nxt;
  logic [TIME_W-1:0] cmp_r   [NUM_HARTS];
  logic [TIME_W-1:0] cmp_nxt [NUM_HARTS];
  logic [TIME_W-1:0] sel_cmp;
  logic [TIME_W-1:0] target;
  logic [TIME_W-1:0] merged;
  logic              is_access;
  logic              do_write;

  assign is_access = (opcode == OP_READ) || (opcode == OP_WRITE);
  assign do_write  = (opcode == OP_WRITE) && acc.hit;
  assign sel_cmp   = cmp_r[acc.hart[HART_W-1:0]];
  assign target    = acc.is_time ? time_r : sel_cmp;
  assign merged    = acc.hi_half ? {write_word, target[WORD_W-1:0]}
                                 : {target[TIME_W-1:WORD_W], write_word};

  always_comb begin
    read_nxt = '0;
    if ((opcode == OP_READ) && acc.hit) begin
      read_nxt = acc.hi_half ? target[TIME_W-1:WORD_W] : target[WORD_W-1:0];
    end
  end

  assign bad_nxt = is_access && !acc.hit;

  always_comb begin
    time_nxt = time_r;
    if (opcode == OP_TICK) begin
      time_nxt = time_r + TIME_W'(1);
    end else if (do_write && acc.is_time) begin
      time_nxt = merged;
    end
  end

  always_comb begin
    for (int h = 0; h < NUM_HARTS; h++) begin
      cmp_nxt[h] = cmp_r[h];
      if (do_write && !acc.is_time && (acc.hart == HART_IDX_W'(h))) begin
        cmp_nxt[h] = merged;
      end
    end
  end

  for (genvar b = 0; b < PEND_W; b++) begin : g_pend
    if (b < NUM_HARTS) begin : g_live
      assign pending_nxt[b] = (time_nxt >= cmp_nxt[b]);
    end else begin : g_none
      assign pending_nxt[b] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= '0;
      for (int h = 0; h < NUM_HARTS; h++) begin
        cmp_r[h] <= '1;
      end
    end else if (upd) begin
      time_r <= time_nxt;
      for (int h = 0; h < NUM_HARTS; h++) begin
        cmp_r[h] <= cmp_nxt[h];
      end
    end
  end

endmodule

>>> rtl/core_local_timer_compare_unit_chk.sv
// Port-level checker for the core-local timer compare unit, bound to the top level.
// Depends on clt_pkg and core_local_timer_compare_unit_macros.svh.
`include "core_local_timer_compare_unit_macros.svh"

module core_local_timer_compare_unit_chk import clt_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [WORD_W-1:0] out_read_word,
  input logic              out_bad_offset,
  input logic [PEND_W-1:0] out_timer_pending
);

  logic in_acc;
  logic out_stall;

  assign in_acc    = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  `CLT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_read_word) && $stable(out_bad_offset) && $stable(out_timer_pending))
  `CLT_ASSERT_IMPLY(a_bad_reads_zero, clk, rst_n, out_valid && out_bad_offset, out_read_word == '0)
  `CLT_ASSERT_NEXT(a_item_reaches_out, clk, rst_n, in_acc ##1 (!out_valid || out_ready), out_valid)
  `CLT_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid && in_ready)

endmodule

bind core_local_timer_compare_unit core_local_timer_compare_unit_chk u_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_item.valid),
  .in_ready         (in_item.ready),
  .out_valid        (out_item.valid),
  .out_ready        (out_item.ready),
  .out_read_word    (out_item.read_word),
  .out_bad_offset   (out_item.bad_offset),
  .out_timer_pending(out_item.timer_pending)
);
